>>> hw/rtl/mccb_pkg.sv
// ----------------------------------------------------------------------------
// mccb_pkg
// Shared types and constants for the motion controller command builder:
// item kinds, link states, special actions and the pot direction table.
// ----------------------------------------------------------------------------
package mccb_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] link_t;
	typedef logic [1:0] action_t;
	typedef logic [1:0] phase_t;

	localparam kind_t KIND_TICK    = 2'd0;
	localparam kind_t KIND_TIMEOUT = 2'd1;
	localparam kind_t KIND_UNPAIR  = 2'd2;
	localparam kind_t KIND_NONE    = 2'd3;

	localparam link_t LINK_UNPAIRED = 2'd0;
	localparam link_t LINK_OTHER    = 2'd3;

	localparam action_t ACT_NONE   = 2'd0;
	localparam action_t ACT_BRAKE  = 2'd1;
	localparam action_t ACT_UNPAIR = 2'd2;

	localparam phase_t PHASE_FIRST = 2'd0;
	localparam phase_t PHASE_BACK  = 2'd1;
	localparam phase_t PHASE_FINAL = 2'd2;

	// register indexes on the configuration port
	localparam logic [2:0] REG_POSITIVE_CAP = 3'd0;
	localparam logic [2:0] REG_NEGATIVE_CAP = 3'd1;
	localparam logic [2:0] REG_DEAD_ZONE    = 3'd2;
	localparam logic [2:0] REG_FIRST_SHAKE  = 3'd3;
	localparam logic [2:0] REG_BACK_SHAKE   = 3'd4;
	localparam logic [2:0] REG_FINAL_SHAKE  = 3'd5;

	localparam logic [14:0] POSITIVE_CAP_RST = 15'd18000;
	localparam logic [15:0] NEGATIVE_CAP_RST = 16'd15000;
	localparam logic [6:0]  DEAD_ZONE_RST    = 7'd25;
	localparam logic [14:0] FIRST_SHAKE_RST  = 15'd16000;
	localparam logic [15:0] BACK_SHAKE_RST   = 16'd12000;
	localparam logic [14:0] FINAL_SHAKE_RST  = 15'd12000;

	// quantize the pot reading into one of eleven direction steps
	function automatic logic signed [7:0] pot_direction(input logic [11:0] pot);
		logic signed [7:0] d;
		priority if (pot < 12'd582)  d = -8'sd128;
		else if (pot < 12'd653)  d = -8'sd102;
		else if (pot < 12'd718)  d = -8'sd77;
		else if (pot < 12'd759)  d = -8'sd51;
		else if (pot < 12'd829)  d = -8'sd26;
		else if (pot < 12'd935)  d = 8'sd0;
		else if (pot < 12'd1186) d = 8'sd25;
		else if (pot < 12'd1606) d = 8'sd51;
		else if (pot < 12'd2216) d = 8'sd76;
		else if (pot < 12'd3014) d = 8'sd102;
		else d = 8'sd127;
		return d;
	endfunction

	// active-low selector pins to selector number
	function automatic logic [2:0] selector_number(input logic [3:0] pins);
		logic [2:0] n;
		priority if (!pins[0]) n = 3'd1;
		else if (!pins[1]) n = 3'd0;
		else if (!pins[2]) n = 3'd3;
		else if (!pins[3]) n = 3'd2;
		else n = 3'd5;
		return n;
	endfunction

endpackage

>>> hw/rtl/motion_controller_command_builder.sv
// Flow: an accepted item passes PREP, then DIV (measured items only), then FIN, where its
// word is loaded into the output register once that register is empty or being taken.
// Items are taken only in IDLE, after the previous word is loaded; the divider has 7 steps.
// Reset: arst_n clears control state, shake detector, team latch and loads register defaults.
// ----------------------------------------------------------------------------
// motion_controller_command_builder
// Builds one command word per input word: shake detection, team/unpair handling,
// clamped speed scaled through a bit-serial restoring divider, pot direction.
// ----------------------------------------------------------------------------
module motion_controller_command_builder (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [15:0]       gyro_y_raw,
	input  logic [15:0]       accel_z_raw,
	input  logic [11:0]       pot_level,
	input  logic [1:0]        link_state,
	input  logic              team_pin,
	input  logic [3:0]        selector_pins,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              measured,
	output logic signed [7:0] speed,
	output logic signed [7:0] direction,
	output logic [1:0]        special_action,
	output logic              hook_shake,
	output logic              restart_window,
	output logic [7:0]        request_byte
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// configuration registers
	logic [14:0] pos_cap_q;
	logic [15:0] neg_cap_q;
	logic [6:0]  dead_zone_q;
	logic [14:0] first_lvl_q;
	logic [15:0] back_lvl_q;
	logic [14:0] final_lvl_q;

	// block state
	logic                 armed_q;
	mccb_pkg::phase_t     phase_q;
	logic                 unpair_q;
	logic                 team_q;
	logic [1:0]           state_q;

	// item registers
	logic                 meas_q;
	logic                 hook_q;
	logic                 restart_q;
	mccb_pkg::action_t    action_q;
	logic [7:0]           req_q;
	logic signed [7:0]    dir_q;
	logic [15:0]          zraw_q;

	// divider
	logic [21:0]          rem_q;
	logic [21:0]          dsh_q;
	logic [6:0]           quo_q;
	logic [2:0]           cnt_q;
	logic                 neg_q;
	logic                 zero_q;

	// output register
	logic                 out_valid_q;
	logic                 o_meas_q;
	logic signed [7:0]    o_speed_q;
	logic signed [7:0]    o_dir_q;
	mccb_pkg::action_t    o_action_q;
	logic                 o_hook_q;
	logic                 o_restart_q;
	logic [7:0]           o_req_q;

	// accept-time decode
	logic                 accept;
	logic                 is_meas;
	logic signed [16:0]   gyro;
	mccb_pkg::phase_t     phase_d;
	logic                 unpair_d;
	logic                 team_d;
	logic                 hook_d;
	logic                 restart_d;
	logic                 brake_d;
	mccb_pkg::action_t    action_d;

	// prep-time clamp
	logic signed [16:0]   zs;
	logic [15:0]          mag;
	logic                 mag_neg;
	logic [15:0]          divisor;
	logic [22:0]          prod;

	// divider step and finish
	logic [22:0]          trial;
	logic [6:0]           q_eff;
	logic signed [7:0]    speed_d;
	logic                 load_out;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_meas  = armed_q && (kind != mccb_pkg::KIND_UNPAIR) && (kind != mccb_pkg::KIND_NONE);

	// shake detector and team handling for a measured word
	always_comb begin
		gyro      = {1'b0, 16'(16'd0 - gyro_y_raw)};
		gyro      = {gyro[15], gyro[15:0]};
		phase_d   = phase_q;
		unpair_d  = unpair_q;
		team_d    = (link_state == mccb_pkg::LINK_UNPAIRED) ? team_pin : team_q;
		hook_d    = 1'b0;
		restart_d = 1'b0;
		brake_d   = 1'b0;
		if (link_state != mccb_pkg::LINK_OTHER) begin
			unique case (phase_q)
				mccb_pkg::PHASE_FIRST: begin
					if (gyro > $signed({2'b00, first_lvl_q})) begin
						restart_d = 1'b1;
						phase_d   = mccb_pkg::PHASE_BACK;
					end
				end
				mccb_pkg::PHASE_BACK: begin
					if (gyro < -$signed({1'b0, back_lvl_q})) begin
						restart_d = 1'b1;
						phase_d   = mccb_pkg::PHASE_FINAL;
					end else if (kind == mccb_pkg::KIND_TIMEOUT) begin
						phase_d = mccb_pkg::PHASE_FIRST;
					end
				end
				mccb_pkg::PHASE_FINAL: begin
					if (gyro > $signed({2'b00, final_lvl_q})) begin
						if (link_state == mccb_pkg::LINK_UNPAIRED) begin
							hook_d   = 1'b1;
							unpair_d = 1'b0;
						end else begin
							brake_d = 1'b1;
						end
						phase_d = mccb_pkg::PHASE_FIRST;
					end else if (kind == mccb_pkg::KIND_TIMEOUT) begin
						phase_d = mccb_pkg::PHASE_FIRST;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		priority if (unpair_d || (team_d != team_pin)) action_d = mccb_pkg::ACT_UNPAIR;
		else if (brake_d) action_d = mccb_pkg::ACT_BRAKE;
		else action_d = mccb_pkg::ACT_NONE;
	end

	// clamp negated z and form magnitude * 127
	always_comb begin
		zs = {1'b0, 16'(16'd0 - zraw_q)};
		zs = {zs[15], zs[15:0]};
		priority if (zs > $signed({2'b00, pos_cap_q})) begin
			mag     = {1'b0, pos_cap_q};
			mag_neg = 1'b0;
		end else if (zs < -$signed({1'b0, neg_cap_q})) begin
			mag     = neg_cap_q;
			mag_neg = 1'b1;
		end else if (zs[16]) begin
			mag     = 16'(-zs);
			mag_neg = 1'b1;
		end else begin
			mag     = zs[15:0];
			mag_neg = 1'b0;
		end
		divisor = mag_neg ? neg_cap_q : {1'b0, pos_cap_q};
		prod    = {mag, 7'd0} - {7'd0, mag};
	end

	always_comb begin
		trial    = {1'b0, rem_q} - {1'b0, dsh_q};
		q_eff    = zero_q ? 7'd0 : quo_q;
		if (q_eff < dead_zone_q) begin
			speed_d = 8'sd0;
		end else if (neg_q) begin
			speed_d = $signed({1'b0, q_eff});
		end else begin
			speed_d = -$signed({1'b0, q_eff});
		end
		load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cap_q   <= mccb_pkg::POSITIVE_CAP_RST;
			neg_cap_q   <= mccb_pkg::NEGATIVE_CAP_RST;
			dead_zone_q <= mccb_pkg::DEAD_ZONE_RST;
			first_lvl_q <= mccb_pkg::FIRST_SHAKE_RST;
			back_lvl_q  <= mccb_pkg::BACK_SHAKE_RST;
			final_lvl_q <= mccb_pkg::FINAL_SHAKE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mccb_pkg::REG_POSITIVE_CAP: pos_cap_q   <= cfg_data[14:0];
				mccb_pkg::REG_NEGATIVE_CAP: neg_cap_q   <= cfg_data;
				mccb_pkg::REG_DEAD_ZONE:    dead_zone_q <= cfg_data[6:0];
				mccb_pkg::REG_FIRST_SHAKE:  first_lvl_q <= cfg_data[14:0];
				mccb_pkg::REG_BACK_SHAKE:   back_lvl_q  <= cfg_data;
				mccb_pkg::REG_FINAL_SHAKE:  final_lvl_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// control: accept, divide, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			armed_q     <= 1'b0;
			phase_q     <= mccb_pkg::PHASE_FIRST;
			unpair_q    <= 1'b0;
			team_q      <= 1'b0;
			meas_q      <= 1'b0;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						armed_q <= 1'b1;
						meas_q  <= is_meas;
						state_q <= ST_PREP;
						if (armed_q && kind == mccb_pkg::KIND_UNPAIR) begin
							unpair_q <= 1'b1;
						end
						if (is_meas) begin
							phase_q  <= phase_d;
							unpair_q <= unpair_d;
							team_q   <= team_d;
						end
					end
				end
				ST_PREP: begin
					cnt_q   <= 3'd6;
					state_q <= meas_q ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: item fields and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			hook_q    <= hook_d;
			restart_q <= restart_d;
			action_q  <= action_d;
			req_q     <= {team_d, 4'd0, mccb_pkg::selector_number(selector_pins)};
			dir_q     <= mccb_pkg::pot_direction(pot_level);
			zraw_q    <= accel_z_raw;
		end
		if (state_q == ST_PREP) begin
			rem_q  <= prod[21:0];
			dsh_q  <= {divisor, 6'd0};
			neg_q  <= mag_neg;
			zero_q <= (mag == 16'd0);
			quo_q  <= 7'd0;
		end
		if (state_q == ST_DIV) begin
			// one quotient bit per cycle, divisor walks right
			if (!trial[22]) begin
				rem_q <= trial[21:0];
			end
			quo_q <= {quo_q[5:0], !trial[22]};
			dsh_q <= {1'b0, dsh_q[21:1]};
		end
		if (load_out) begin
			o_meas_q    <= meas_q;
			o_speed_q   <= meas_q ? speed_d : 8'sd0;
			o_dir_q     <= meas_q ? dir_q : 8'sd0;
			o_action_q  <= meas_q ? action_q : mccb_pkg::ACT_NONE;
			o_hook_q    <= meas_q && hook_q;
			o_restart_q <= meas_q && restart_q;
			o_req_q     <= meas_q ? req_q : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign measured       = o_meas_q;
	assign speed          = o_speed_q;
	assign direction      = o_dir_q;
	assign special_action = o_action_q;
	assign hook_shake     = o_hook_q;
	assign restart_window = o_restart_q;
	assign request_byte   = o_req_q;

endmodule
